>>> hdl/uwbpm_pkg.sv
// Shared types, constants and status codes of the wildcard byte pattern matcher.
// Used by every module under hdl; depends on nothing.
package uwbpm_pkg;

    // default sizes, handed to the top-level parameters
    localparam int PATTERN_MAX_DEF  = 16;
    localparam int OFFSET_WIDTH_DEF = 32;

    // fixed register and field geometry
    localparam int PAT_BYTES    = 16;   // pattern bytes held by the two pattern words
    localparam int LEN_W        = 5;
    localparam int STATUS_W     = 3;
    localparam int OFFSET_OUT_W = 32;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
    localparam logic [STATUS_W-1:0] ST_MULTIPLE  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd4;

    // register indexes (byte address / 8)
    localparam logic [1:0] REG_PAT_LO = 2'd0;
    localparam logic [1:0] REG_PAT_HI = 2'd1;
    localparam logic [1:0] REG_WILD   = 2'd2;
    localparam logic [1:0] REG_LEN    = 2'd3;

    typedef logic [PAT_BYTES-1:0][7:0] pattern_t;

    // per-byte control from the window chain to the tally
    typedef struct packed {
        logic             accept;
        logic             final_byte;
        logic             window_hit;
        logic             len_valid;
        logic [LEN_W-1:0] pat_len;
    } scan_ctl_t;

    // one scan result
    typedef struct packed {
        logic [OFFSET_OUT_W-1:0] match_offset;
        logic [STATUS_W-1:0]     scan_status;
    } scan_res_t;

endpackage

>>> hdl/unique_wildcard_byte_pattern_match.sv
// Top level of the wildcard byte pattern matcher: config registers, the chain
// of window cells, the tally and the result register. Uses uwbpm_pkg, uwbpm_cell, uwbpm_tally.
// The result is registered onto m_tvalid in the cycle after the final byte's transaction.
// Throughput: one byte per cycle; the masked window compare and tally update are combinational.
// The input stalls only while a result sits unaccepted and m_tready is low.
// Reset: synchronous active-low aresetn clears config registers, counters and the result valid.
module unique_wildcard_byte_pattern_match import uwbpm_pkg::*; #(
    parameter int PATTERN_MAX  = PATTERN_MAX_DEF,
    parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic        s_tlast,    // final_byte
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // [2:0] scan_status, [34:3] match_offset, rest zero
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    logic [63:0]          pat_lo_reg;
    logic [63:0]          pat_hi_reg;
    logic [PAT_BYTES-1:0] wild_reg;
    logic [LEN_W-1:0]     len_reg;
    logic [1:0]           reg_idx;
    logic                 cfg_wr;

    pattern_t             pattern;
    logic                 s_accept;
    logic [PATTERN_MAX-1:0] hits;
    logic [7:0]           chain [PATTERN_MAX+1];
    scan_ctl_t            ctl;
    logic                 res_valid;
    scan_res_t            res;
    scan_res_t            res_reg;
    logic                 m_valid_reg;

    // register port
    assign pready  = 1'b1;
    assign reg_idx = paddr[4:3];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_lo_reg <= '0;
            pat_hi_reg <= '0;
            wild_reg   <= '0;
            len_reg    <= '0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_PAT_LO: pat_lo_reg <= pwdata;
                REG_PAT_HI: pat_hi_reg <= pwdata;
                REG_WILD:   wild_reg   <= pwdata[PAT_BYTES-1:0];
                REG_LEN:    len_reg    <= pwdata[LEN_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_PAT_LO: prdata = pat_lo_reg;
            REG_PAT_HI: prdata = pat_hi_reg;
            REG_WILD:   prdata = 64'(wild_reg);
            REG_LEN:    prdata = 64'(len_reg);
            default:    prdata = '0;
        endcase
    end

    assign pattern = {pat_hi_reg, pat_lo_reg};

    // handshake: new byte whenever the result slot is free or draining
    assign s_tready = !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    // window cell chain, newest byte in cell 0
    assign chain[0] = s_tdata;
    for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
        uwbpm_cell #(
            .CELL_IDX (j)
        ) u_cell (
            .aclk      (aclk),
            .shift_en  (s_accept),
            .byte_in   (chain[j]),
            .pattern   (pattern),
            .wild_mask (wild_reg),
            .pat_len   (len_reg),
            .byte_out  (chain[j+1]),
            .hit       (hits[j])
        );
    end

    // control to the tally
    always_comb begin
        ctl.accept     = s_accept;
        ctl.final_byte = s_tlast;
        ctl.window_hit = &hits;
        ctl.len_valid  = (len_reg != '0) && (32'(len_reg) <= PATTERN_MAX)
                         && (32'(len_reg) <= PAT_BYTES);
        ctl.pat_len    = len_reg;
    end

    uwbpm_tally #(
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) u_tally (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl),
        .res_valid (res_valid),
        .res       (res)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, res_reg.match_offset, res_reg.scan_status};

    // a final byte always produces a result next cycle
    a_final_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> m_tvalid)
        else $error("final byte without result");

    // a pending, stalled result blocks the input
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input accepted over a stalled result");

    // offset is zero unless the status is found
    a_offset_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res_reg.scan_status != ST_FOUND |-> res_reg.match_offset == '0)
        else $error("nonzero offset on a status other than found");

endmodule

>>> hdl/uwbpm_cell.sv
// One window cell: holds one buffered byte, passes it on to its neighbor on
// every accepted byte, and compares its incoming byte with its pattern byte. Uses uwbpm_pkg.
module uwbpm_cell import uwbpm_pkg::*; #(
    parameter int CELL_IDX = 0
) (
    input  logic             aclk,
    input  logic             shift_en,
    input  logic [7:0]       byte_in,
    input  pattern_t         pattern,
    input  logic [PAT_BYTES-1:0] wild_mask,
    input  logic [LEN_W-1:0] pat_len,
    output logic [7:0]       byte_out,
    output logic             hit
);

    logic [7:0] byte_reg;
    logic       in_use;
    logic [6:0] sel_full;
    logic [3:0] sel;

    // window byte; content before a full pattern span is never compared, so no reset
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            byte_reg <= byte_in;
        end
    end

    assign byte_out = byte_reg;

    // this cell covers pattern byte len-1-idx when idx < len
    assign in_use   = (32'(pat_len) > CELL_IDX);
    assign sel_full = 7'(pat_len) - 7'(CELL_IDX) - 7'd1;
    assign sel      = sel_full[3:0];

    // compare against the byte that enters this cell
    assign hit = !in_use || wild_mask[sel] || (byte_in == pattern[sel]);

endmodule

>>> hdl/uwbpm_tally.sv
// Match tally: byte counter, match counter, first match offset and the
// end-of-buffer result. Uses uwbpm_pkg.
module uwbpm_tally import uwbpm_pkg::*; #(
    parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  scan_ctl_t ctl,
    output logic      res_valid,
    output scan_res_t res
);

    logic [OFFSET_WIDTH-1:0]    seen_reg, seen_next;
    logic [OFFSET_WIDTH-1:0]    first_reg, first_next;
    logic [1:0]                 matches_reg, matches_next;
    logic                       ovf_reg, ovf_next;
    logic                       seen_max;
    logic                       cmp_en;
    logic                       match;
    logic [OFFSET_WIDTH+31:0]   first_ext;

    // counter update for this byte
    always_comb begin
        seen_max     = &seen_reg;
        ovf_next     = ovf_reg || seen_max;
        seen_next    = seen_max ? seen_reg : seen_reg + OFFSET_WIDTH'(1);
        cmp_en       = ctl.len_valid && !ovf_next && (seen_next >= OFFSET_WIDTH'(ctl.pat_len));
        match        = cmp_en && ctl.window_hit;
        first_next   = first_reg;
        matches_next = matches_reg;
        if (match && matches_reg == 2'd0) begin
            first_next = seen_next - OFFSET_WIDTH'(ctl.pat_len);
        end
        if (match && matches_reg != 2'd2) begin
            matches_next = matches_reg + 2'd1;
        end
    end

    // result on the final byte
    assign first_ext = {32'b0, first_next};
    always_comb begin
        res.match_offset = '0;
        if (!ctl.len_valid) begin
            res.scan_status = ST_INVALID;
        end else if (ovf_next) begin
            res.scan_status = ST_OVERFLOW;
        end else if (matches_next == 2'd0) begin
            res.scan_status = ST_NOT_FOUND;
        end else if (matches_next == 2'd2) begin
            res.scan_status = ST_MULTIPLE;
        end else begin
            res.scan_status  = ST_FOUND;
            res.match_offset = first_ext[OFFSET_OUT_W-1:0];
        end
    end

    assign res_valid = ctl.accept && ctl.final_byte;

    // scan state; cleared after the final byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg    <= '0;
            first_reg   <= '0;
            matches_reg <= '0;
            ovf_reg     <= 1'b0;
        end else if (ctl.accept) begin
            if (ctl.final_byte) begin
                seen_reg    <= '0;
                first_reg   <= '0;
                matches_reg <= '0;
                ovf_reg     <= 1'b0;
            end else begin
                seen_reg    <= seen_next;
                first_reg   <= first_next;
                matches_reg <= matches_next;
                ovf_reg     <= ovf_next;
            end
        end
    end

    // match count saturates at two
    a_matches_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        matches_reg != 2'd3)
        else $error("match count beyond saturation");

    // a final byte clears the tally
    a_clear_after_final: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.accept && ctl.final_byte |=> seen_reg == '0 && matches_reg == 2'd0 && !ovf_reg)
        else $error("tally not cleared after final byte");

    // overflow is sticky within a buffer
    a_ovf_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        ovf_reg && !(ctl.accept && ctl.final_byte) |=> ovf_reg)
        else $error("overflow flag dropped mid-buffer");

endmodule

>>> bench/tb_unique_wildcard_byte_pattern_match.sv
// Self-checking testbench for unique_wildcard_byte_pattern_match: streams byte buffers,
// predicts each per-buffer scan result and checks it against the result stream.
// Depends on uwbpm_pkg and the RTL under hdl; needs nothing else.
module tb_unique_wildcard_byte_pattern_match;
    timeunit 1ns;
    timeprecision 1ps;
    import uwbpm_pkg::*;

    localparam int RANDOM_ITEMS = 1250;
    localparam int QUIET_LIMIT  = 5000;
    localparam int HOLD_OFF     = 300;

    // buffer shapes for the random part
    typedef enum int { BUF_PLANTED, BUF_SHORT, BUF_NOISE } buf_kind_t;

    // Scan predictor: mirrors the registers and per-buffer scan state,
    // queues one expected result per final byte.
    class scan_scoreboard;
        logic [63:0]                pat_lo = '0;
        logic [63:0]                pat_hi = '0;
        logic [15:0]                wild = '0;
        logic [LEN_W-1:0]           pat_len = '0;
        logic [PAT_BYTES-1:0][7:0]  window = '0;
        logic [31:0]                bytes_seen = '0;
        logic [1:0]                 match_count = '0;
        logic [31:0]                first_start = '0;
        logic                       overflowed = 1'b0;
        scan_res_t                  expected_results[$];
        int                         fails = 0;
        int                         checked = 0;

        function void write_reg(logic [1:0] idx, logic [63:0] val);
            case (idx)
                REG_PAT_LO: pat_lo = val;
                REG_PAT_HI: pat_hi = val;
                REG_WILD:   wild = val[15:0];
                REG_LEN:    pat_len = val[LEN_W-1:0];
                default: ;
            endcase
        endfunction

        // one accepted input transaction
        function void note_byte(logic [7:0] b, logic fin);
            logic [PAT_BYTES-1:0][7:0] pat;
            logic                      len_ok;
            logic                      hit;
            scan_res_t                 res;
            pat = {pat_hi, pat_lo};
            len_ok = (pat_len >= 1) && (pat_len <= PATTERN_MAX_DEF) && (pat_len <= PAT_BYTES);
            window = {window[PAT_BYTES-2:0], b};
            if (bytes_seen == 32'hFFFF_FFFF) overflowed = 1'b1;
            else bytes_seen = bytes_seen + 1;

            // oldest byte of the window lines up with pattern byte 0
            if (len_ok && !overflowed && bytes_seen >= 32'(pat_len)) begin
                hit = 1'b1;
                for (int k = 0; k < PAT_BYTES; k++)
                    if (k < int'(pat_len) && !wild[k] && window[int'(pat_len) - 1 - k] != pat[k])
                        hit = 1'b0;
                if (hit) begin
                    if (match_count == 0) first_start = bytes_seen - 32'(pat_len);
                    if (match_count < 2) match_count = match_count + 1;
                end
            end
            if (!fin) return;

            res.match_offset = '0;
            if (!len_ok) res.scan_status = ST_INVALID;
            else if (overflowed) res.scan_status = ST_OVERFLOW;
            else if (match_count == 0) res.scan_status = ST_NOT_FOUND;
            else if (match_count >= 2) res.scan_status = ST_MULTIPLE;
            else begin
                res.scan_status  = ST_FOUND;
                res.match_offset = first_start;
            end
            expected_results = {expected_results, res};
            window = '0;
            bytes_seen = '0;
            match_count = '0;
            first_start = '0;
            overflowed = 1'b0;
        endfunction

        // one accepted result transaction
        function void check_result(logic [STATUS_W-1:0] st, logic [OFFSET_OUT_W-1:0] off);
            scan_res_t want;
            if (expected_results.size() == 0) begin
                fails++;
                if (fails <= 10)
                    $display("unexpected result: status %0d offset %0d", st, off);
                return;
            end
            want = expected_results.pop_front();
            checked++;
            if (st !== want.scan_status || off !== want.match_offset) begin
                fails++;
                if (fails <= 10)
                    $display("result %0d: status exp %0d got %0d, offset exp %0d got %0d",
                             checked, want.scan_status, st, want.match_offset, off);
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;      // [7:0] data_byte
    logic        s_tlast = 1'b0;    // final_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;           // [2:0] scan_status, [34:3] match_offset
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    scan_scoreboard sb = new();

    // stimulus state
    logic [PAT_BYTES-1:0][7:0] cur_pat;
    logic [15:0]               cur_mask;
    logic [LEN_W-1:0]          cur_len;
    logic                      narrow = 1'b0;
    logic                      steady_flow = 1'b0;
    int                        hold_cycles = 0;
    logic [7:0]                staged[$];
    int                        items_sent = 0;
    int                        buffers_sent = 0;
    int                        settings_used = 0;
    int                        directed_items;
    int                        quiet_cycles = 0;

    unique_wildcard_byte_pattern_match dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // result side: random stalls, a counted hold-off on request
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                hold_cycles--;
            end else begin
                m_tready <= steady_flow || ($urandom_range(99) >= 20);
            end
        end
    end

    // check every result transaction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata[2:0], m_tdata[34:3]);
    end

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
            $display("tb_unique_wildcard_byte_pattern_match NOT OK");
            $finish;
        end
    end

    function automatic logic [7:0] pick_byte();
        return narrow ? 8'($urandom_range(3)) : 8'($urandom_range(255));
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [63:0] val);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.write_reg(idx, val);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apply_config(logic [63:0] lo, logic [63:0] hi, logic [63:0] mask,
                                logic [63:0] len);
        write_reg(REG_PAT_LO, lo);
        write_reg(REG_PAT_HI, hi);
        write_reg(REG_WILD, mask);
        write_reg(REG_LEN, len);
        settings_used++;
    endtask

    // send the staged bytes as one buffer, flag on the last byte
    task automatic send_staged();
        logic fin;
        for (int i = 0; i < staged.size(); i++) begin
            fin = (i == staged.size() - 1);
            @(negedge aclk);
            while (!steady_flow && $urandom_range(99) < 20) begin
                s_tvalid <= 1'b0;
                @(negedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= staged[i];
            s_tlast  <= fin;
            do @(posedge aclk); while (!s_tready);
            sb.note_byte(staged[i], fin);
            items_sent++;
        end
        staged.delete();
        buffers_sent++;
    endtask

    // build one random buffer of the given shape and send it
    task automatic send_buffer(buf_kind_t kind);
        int eff_len;
        int copies;
        eff_len = (cur_len > PAT_BYTES) ? PAT_BYTES : int'(cur_len);
        staged.delete();
        case (kind)
            BUF_PLANTED: begin
                copies = $urandom_range(2);
                repeat ($urandom_range(6)) staged = {staged, pick_byte()};
                repeat (copies) begin
                    for (int k = 0; k < eff_len; k++)
                        staged = {staged, (cur_mask[k] ? pick_byte() : cur_pat[k])};
                    repeat ($urandom_range(4)) staged = {staged, pick_byte()};
                end
                repeat ($urandom_range(3)) staged = {staged, pick_byte()};
            end
            // shorter than the pattern where the pattern allows it
            BUF_SHORT: repeat ($urandom_range(1, (eff_len > 1) ? eff_len - 1 : 1))
                staged = {staged, pick_byte()};
            default: repeat ($urandom_range(1, 24)) staged = {staged, pick_byte()};
        endcase
        if (staged.size() == 0) staged = {staged, pick_byte()};
        send_staged();
    endtask

    // drop valid and let every outstanding result drain
    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    initial begin
        int r;
        int phase;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        // directed: reset config has length zero
        staged = '{8'h00, 8'hFF};
        send_staged();
        wait_idle();

        // single-byte pattern: found, multiple, not found
        apply_config(64'hFF, 64'h0, 64'h0, 64'd1);
        staged = '{8'hFF};
        send_staged();
        staged = '{8'h00, 8'hFF, 8'hFF};
        send_staged();
        staged = '{8'h00};
        send_staged();
        wait_idle();

        // full-length all-wildcard pattern, then a buffer shorter than it
        apply_config('1, '1, 64'hFFFF, 64'd16);
        repeat (16) staged = {staged, 8'($urandom_range(255))};
        send_staged();
        staged = '{8'h5A};
        send_staged();
        wait_idle();

        // largest length code is out of range
        apply_config(64'h0, 64'h0, 64'h0, 64'd31);
        staged = '{8'h00};
        send_staged();
        wait_idle();
        directed_items = items_sent;

        // random phases: new settings, then a handful of buffers
        phase = 0;
        while (items_sent - directed_items < RANDOM_ITEMS) begin
            r = $urandom_range(99);
            if (r < 8) cur_len = $urandom_range(1) ? 5'd0 : 5'($urandom_range(17, 31));
            else if (r < 16) cur_len = 5'd16;
            else if (r < 24) cur_len = 5'd1;
            else cur_len = 5'($urandom_range(2, 15));
            narrow = ($urandom_range(3) == 0);
            for (int k = 0; k < PAT_BYTES; k++) cur_pat[k] = pick_byte();
            case ($urandom_range(3))
                0: cur_mask = '0;
                1: cur_mask = 16'($urandom & $urandom);
                2: cur_mask = 16'($urandom);
                default: cur_mask = '1;
            endcase
            // junk in the unused upper bits of the narrow registers
            apply_config(cur_pat[7:0], cur_pat[15:8],
                         {32'($urandom), 16'($urandom), cur_mask},
                         {32'($urandom), 27'($urandom), cur_len});
            steady_flow = (phase == 2 || phase == 3);
            if (phase == 5) hold_cycles = HOLD_OFF;
            repeat ($urandom_range(3, 8)) begin
                r = $urandom_range(99);
                send_buffer(r < 70 ? BUF_PLANTED : (r < 85 ? BUF_SHORT : BUF_NOISE));
            end
            wait_idle();
            phase++;
        end

        steady_flow = 1'b0;
        wait_idle();
        repeat (10) @(posedge aclk);

        $display("ran %0d bytes in %0d buffers under %0d register settings",
                 items_sent, buffers_sent, settings_used);
        $display("%0d results checked, %0d failures, %0d results missing",
                 sb.checked, sb.fails, sb.pending());
        if (sb.fails == 0 && sb.pending() == 0) begin
            $display("tb_unique_wildcard_byte_pattern_match OK");
        end else begin
            $display("tb_unique_wildcard_byte_pattern_match NOT OK");
        end
        $finish;
    end

endmodule

>>> sim.f
hdl/uwbpm_pkg.sv
hdl/uwbpm_cell.sv
hdl/uwbpm_tally.sv
hdl/unique_wildcard_byte_pattern_match.sv
bench/tb_unique_wildcard_byte_pattern_match.sv
